// ===== src/gbs_pkg.sv =====
// Shared constants and types of the grid bilinear sampler.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int GRID_WORDS      = 2048;
    localparam int ADDR_W          = $clog2(GRID_WORDS);
    localparam int COORD_FRAC_BITS = 10;
    localparam int COORD_W         = 24;
    localparam int DATA_W          = 32;
    localparam int SIDE_W          = 6;
    localparam int ENTRY_W         = 3 * DATA_W;
    localparam int WEIGHT_W        = COORD_FRAC_BITS + 1;
    localparam int ACC_W           = DATA_W + WEIGHT_W + 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << COORD_FRAC_BITS;

    // one step of the shared multiply-accumulate unit
    typedef struct packed {
        logic                     en;
        logic                     clear;
        logic signed [DATA_W-1:0] operand;
        logic [WEIGHT_W-1:0]      weight;
    } mac_op_t;

endpackage

// ===== src/gbs_grid_ram.sv =====
// Grid entry store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module gbs_grid_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [gbs_pkg::ADDR_W-1:0]  waddr,
    input  logic [gbs_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [gbs_pkg::ADDR_W-1:0]  raddr,
    output logic [gbs_pkg::ENTRY_W-1:0] rdata
);
    import gbs_pkg::*;

    logic [ENTRY_W-1:0] grid_mem_reg [GRID_WORDS];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            grid_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= grid_mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gbs_mac_unit.sv =====
// Shared multiply-accumulate unit with floor scaling of the accumulator.
`timescale 1ns / 1ps

module gbs_mac_unit (
    input  logic                              clk,
    input  gbs_pkg::mac_op_t                  op,
    output logic signed [gbs_pkg::DATA_W-1:0] floor_out
);
    import gbs_pkg::*;

    logic signed [WEIGHT_W:0] weight_s;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  acc_reg;

    assign weight_s = $signed({1'b0, op.weight});
    assign prod     = ACC_W'(op.operand) * ACC_W'(weight_s);

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            if (op.clear)
            begin
                acc_reg <= prod;
            end
            else
            begin
                acc_reg <= acc_reg + prod;
            end
        end
    end

    // arithmetic shift right rounds toward minus infinity
    assign floor_out = acc_reg[COORD_FRAC_BITS +: DATA_W];

endmodule

// ===== src/grid_bilinear_sampler_unit.sv =====
// Top level of the grid bilinear sampler: sequencer, coordinate split and datapath.
`timescale 1ns / 1ps
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------------
//  request   | start / busy            | opcode, entry_address, write_x/y/z,
//            |                         | coord_u, coord_v, coord_invalid
//  result    | result_valid (1 cycle)  | sample_x, sample_y, sample_z, skipped
//  config    | cfg_we                  | cfg_wdata (grid_side)
//
//  A write request stores the entry at the accepting edge and busy stays low. An
//  invalid-coordinate sample shows its skipped result in the next cycle. A valid
//  sample holds busy high, and no new request is taken, while it steps through
//  clamping and splitting the coordinates, four corner reads through the single
//  read port, three blends of two products for each of three components on the
//  one shared multiplier, and loading the result. Reset clears the sequencer,
//  the result strobe and grid_side (to 2); the grid store holds no reset value and
//  must be written before it is sampled. The receiver cannot stall: each result is
//  shown for exactly one cycle.

module grid_bilinear_sampler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [10:0]                        entry_address,
    input  logic signed [gbs_pkg::DATA_W-1:0]  write_x,
    input  logic signed [gbs_pkg::DATA_W-1:0]  write_y,
    input  logic signed [gbs_pkg::DATA_W-1:0]  write_z,
    input  logic signed [gbs_pkg::COORD_W-1:0] coord_u,
    input  logic signed [gbs_pkg::COORD_W-1:0] coord_v,
    input  logic                               coord_invalid,
    input  logic                               cfg_we,
    input  logic [gbs_pkg::SIDE_W-1:0]         cfg_wdata,
    output logic                               result_valid,
    output logic signed [gbs_pkg::DATA_W-1:0]  sample_x,
    output logic signed [gbs_pkg::DATA_W-1:0]  sample_y,
    output logic signed [gbs_pkg::DATA_W-1:0]  sample_z,
    output logic                               skipped
);
    import gbs_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int IW = COORD_W - 1 - F;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // blend steps of one component
    localparam logic [2:0] PH_TOP_A = 3'd0;
    localparam logic [2:0] PH_TOP_B = 3'd1;
    localparam logic [2:0] PH_BOT_A = 3'd2;
    localparam logic [2:0] PH_BOT_B = 3'd3;
    localparam logic [2:0] PH_MID_A = 3'd4;
    localparam logic [2:0] PH_MID_B = 3'd5;

    localparam logic [1:0] CMP_X = 2'd0;
    localparam logic [1:0] CMP_Y = 2'd1;
    localparam logic [1:0] CMP_Z = 2'd2;

    localparam logic [2:0] RD_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_MAC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [SIDE_W-1:0] idx;
        logic [SIDE_W-1:0] idx2;
        logic [F-1:0]      frac;
    } split_t;

    state_t               state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [1:0]           comp_reg, comp_next;
    logic [2:0]           phase_reg, phase_next;
    logic [SIDE_W-1:0]    grid_side_reg, grid_side_next;
    logic                 result_valid_reg, result_valid_next;
    logic                 skipped_reg, skipped_next;
    logic signed [DATA_W-1:0] sample_x_reg, sample_x_next;
    logic signed [DATA_W-1:0] sample_y_reg, sample_y_next;
    logic signed [DATA_W-1:0] sample_z_reg, sample_z_next;

    logic signed [COORD_W-1:0] coord_u_reg, coord_v_reg;
    logic [SIDE_W-1:0]    side_reg;
    logic [SIDE_W-1:0]    col_reg, col2_reg, row_reg, row2_reg;
    logic [F-1:0]         frac_u_reg, frac_v_reg;
    logic [ENTRY_W-1:0]   corner_reg [4];
    logic signed [DATA_W-1:0] top_reg, bot_reg, res_x_reg, res_y_reg;

    logic                 accept;
    split_t               split_u, split_v;
    logic [SIDE_W-1:0]    rd_row, rd_col;
    logic [2*SIDE_W-1:0]  rd_sum;
    logic                 ram_we, ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [1:0]           corner_idx;
    mac_op_t              mac_op;
    logic signed [DATA_W-1:0] mac_floor;

    // clamp one coordinate into the grid and split it into cell index and fraction
    function automatic split_t split_coord(input logic signed [COORD_W-1:0] c,
                                           input logic [SIDE_W-1:0] st);
        split_t s;
        s.idx  = '0;
        s.frac = '0;
        if (c[COORD_W-1])
        begin
            s.idx  = '0;
            s.frac = '0;
        end
        else if (c[COORD_W-2:F] >= IW'(st))
        begin
            s.idx  = st - SIDE_W'(1);
            s.frac = '0;
        end
        else
        begin
            s.idx  = c[F +: SIDE_W];
            s.frac = c[F-1:0];
        end
        // neighbour stays on the last column or row
        if (({1'b0, s.idx} + (SIDE_W+1)'(1)) >= {1'b0, st})
        begin
            s.idx2 = st - SIDE_W'(1);
        end
        else
        begin
            s.idx2 = s.idx + SIDE_W'(1);
        end
        return s;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign split_u = split_coord(coord_u_reg, side_reg);
    assign split_v = split_coord(coord_v_reg, side_reg);

    // corner order: (row, col), (row, col2), (row2, col), (row2, col2)
    assign rd_row = cnt_reg[1] ? row2_reg : row_reg;
    assign rd_col = cnt_reg[0] ? col2_reg : col_reg;
    assign rd_sum = (2*SIDE_W)'(rd_row) * (2*SIDE_W)'(side_reg)
                  + {{SIDE_W{1'b0}}, rd_col};

    assign ram_we     = accept && (opcode == OP_WRITE);
    assign ram_re     = (state_reg == ST_READ) && (cnt_reg != RD_LAST);
    assign corner_idx = 2'(cnt_reg - 3'd1);

    gbs_grid_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_address[ADDR_W-1:0]),
        .wdata ({write_z, write_y, write_x}),
        .re    (ram_re),
        .raddr (rd_sum[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // pick operand and weight for the shared multiplier
    always_comb
    begin
        mac_op.en      = (state_reg == ST_MAC);
        mac_op.clear   = !phase_reg[0];
        mac_op.operand = '0;
        mac_op.weight  = '0;
        case (phase_reg)
            PH_TOP_A, PH_BOT_A:
            begin
                mac_op.operand = corner_reg[phase_reg[1:0]][comp_reg*DATA_W +: DATA_W];
                mac_op.weight  = WEIGHT_ONE - {1'b0, frac_u_reg};
            end
            PH_TOP_B, PH_BOT_B:
            begin
                mac_op.operand = corner_reg[phase_reg[1:0]][comp_reg*DATA_W +: DATA_W];
                mac_op.weight  = {1'b0, frac_u_reg};
            end
            PH_MID_A:
            begin
                mac_op.operand = top_reg;
                mac_op.weight  = WEIGHT_ONE - {1'b0, frac_v_reg};
            end
            PH_MID_B:
            begin
                mac_op.operand = bot_reg;
                mac_op.weight  = {1'b0, frac_v_reg};
            end
            default:
            begin
                mac_op.operand = '0;
                mac_op.weight  = '0;
            end
        endcase
    end

    gbs_mac_unit u_mac (
        .clk       (clk),
        .op        (mac_op),
        .floor_out (mac_floor)
    );

    // sequencer next state and result registers
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        comp_next         = comp_reg;
        phase_next        = phase_reg;
        grid_side_next    = cfg_we ? cfg_wdata : grid_side_reg;
        result_valid_next = 1'b0;
        skipped_next      = skipped_reg;
        sample_x_next     = sample_x_reg;
        sample_y_next     = sample_y_reg;
        sample_z_next     = sample_z_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_SAMPLE))
                begin
                    if (coord_invalid)
                    begin
                        // skipped sample: answer at once, leave the store alone
                        result_valid_next = 1'b1;
                        skipped_next      = 1'b1;
                        sample_x_next     = '0;
                        sample_y_next     = '0;
                        sample_z_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (cnt_reg == RD_LAST)
                begin
                    comp_next  = CMP_X;
                    phase_next = PH_TOP_A;
                    state_next = ST_MAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_MAC:
            begin
                if (phase_reg == PH_MID_B)
                begin
                    phase_next = PH_TOP_A;
                    if (comp_reg == CMP_Z)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_FIN:
            begin
                result_valid_next = 1'b1;
                skipped_next      = 1'b0;
                sample_x_next     = res_x_reg;
                sample_y_next     = res_y_reg;
                sample_z_next     = mac_floor;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            comp_reg         <= CMP_X;
            phase_reg        <= PH_TOP_A;
            grid_side_reg    <= SIDE_W'(2);
            result_valid_reg <= 1'b0;
            skipped_reg      <= 1'b0;
            sample_x_reg     <= '0;
            sample_y_reg     <= '0;
            sample_z_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            comp_reg         <= comp_next;
            phase_reg        <= phase_next;
            grid_side_reg    <= grid_side_next;
            result_valid_reg <= result_valid_next;
            skipped_reg      <= skipped_next;
            sample_x_reg     <= sample_x_next;
            sample_y_reg     <= sample_y_next;
            sample_z_reg     <= sample_z_next;
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_u_reg <= coord_u;
            coord_v_reg <= coord_v;
            // a side of zero acts as a side of one
            side_reg    <= (grid_side_reg == '0) ? SIDE_W'(1) : grid_side_reg;
        end
        if (state_reg == ST_SPLIT)
        begin
            col_reg    <= split_u.idx;
            col2_reg   <= split_u.idx2;
            frac_u_reg <= split_u.frac;
            row_reg    <= split_v.idx;
            row2_reg   <= split_v.idx2;
            frac_v_reg <= split_v.frac;
        end
        if ((state_reg == ST_READ) && (cnt_reg != '0))
        begin
            corner_reg[corner_idx] <= ram_rdata;
        end
        if (state_reg == ST_MAC)
        begin
            if (phase_reg == PH_BOT_A)
            begin
                top_reg <= mac_floor;
            end
            if (phase_reg == PH_MID_A)
            begin
                bot_reg <= mac_floor;
            end
            // the previous component finishes while the next one starts
            if ((phase_reg == PH_TOP_A) && (comp_reg == CMP_Y))
            begin
                res_x_reg <= mac_floor;
            end
            if ((phase_reg == PH_TOP_A) && (comp_reg == CMP_Z))
            begin
                res_y_reg <= mac_floor;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign skipped      = skipped_reg;
    assign sample_x     = sample_x_reg;
    assign sample_y     = sample_y_reg;
    assign sample_z     = sample_z_reg;

endmodule

// ===== src/gbs_checker.sv =====
// Port-level assertions of the grid bilinear sampler and their binding.
`timescale 1ns / 1ps

module gbs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              opcode,
    input logic                              coord_invalid,
    input logic                              result_valid,
    input logic signed [gbs_pkg::DATA_W-1:0] sample_x,
    input logic signed [gbs_pkg::DATA_W-1:0] sample_y,
    input logic signed [gbs_pkg::DATA_W-1:0] sample_z,
    input logic                              skipped
);
    import gbs_pkg::*;

    logic acc_write, acc_skip, acc_sample;

    assign acc_write  = start && !busy && !opcode;
    assign acc_skip   = start && !busy && opcode && coord_invalid;
    assign acc_sample = start && !busy && opcode && !coord_invalid;

    // a write request never produces a result
    assert property (@(posedge clk) disable iff (!rst_n) acc_write |=> !result_valid)
        else $error("result after a write request");

    // an invalid sample answers in the next cycle with the skip flag
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_skip |=> (result_valid && skipped))
        else $error("missing skipped result");

    // a skipped result carries a zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && skipped) |-> (sample_x == 0 && sample_y == 0 && sample_z == 0))
        else $error("skipped result with nonzero vector");

    // a valid sample holds the request side off
    assert property (@(posedge clk) disable iff (!rst_n) acc_sample |=> busy)
        else $error("not busy after a valid sample request");

    // a computed result ends a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !skipped) |-> ($past(busy) && !busy))
        else $error("computed result outside the end of a busy period");

endmodule

bind grid_bilinear_sampler_unit gbs_checker u_gbs_checker (.*);

// ===== dv/grid_bilinear_sampler_unit_tb.sv =====
// Self-checking testbench of the grid bilinear sampler: grid writes, clamped samples.
`timescale 1ns / 1ps

module grid_bilinear_sampler_unit_tb;

    import gbs_pkg::*;

    // Random requests issued after the directed part, spread over the side phases.
    localparam int RANDOM_ITEMS = 1300;
    localparam int SIDE_PHASES  = 8;
    // Cycles to wait after the block goes idle, before a register write and before
    // the final verdict.
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_e;

    typedef struct
    {
        op_e                       op;
        logic [ADDR_W-1:0]         addr;
        logic signed [DATA_W-1:0]  wx;
        logic signed [DATA_W-1:0]  wy;
        logic signed [DATA_W-1:0]  wz;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic                      invalid;
    } request_t;

    typedef struct
    {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     skipped;
    } blended_t;

    // Mirror of the grid store and grid_side; turns each accepted request into
    // the blended vector the block must return, and checks returned vectors.
    class grid_mirror;
        logic signed [DATA_W-1:0] store [GRID_WORDS][3];
        logic [SIDE_W-1:0]        side;
        blended_t                 expected_samples [$];
        int                       errors;

        function new();
            side   = 2;
            errors = 0;
        endfunction

        function void set_side(input logic [SIDE_W-1:0] value);
            side = value;
        endfunction

        // a side of zero behaves as a side of one
        function longint eff_side();
            return (side == 0) ? 1 : longint'(side);
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        static function longint blend(input longint a, input longint b, input longint f);
            longint acc;
            acc = a * ((longint'(1) << COORD_FRAC_BITS) - f) + b * f;
            // arithmetic shift floors toward minus infinity
            return acc >>> COORD_FRAC_BITS;
        endfunction

        // Clamp one coordinate into [0, side) and split it into cell and fraction.
        static function void split(input logic signed [COORD_W-1:0] c_in, input longint st,
                                   output longint idx, output longint frac);
            longint c;
            c = c_in;
            if (c < 0)
                c = 0;
            else if (c >= (st << COORD_FRAC_BITS))
                c = (st - 1) << COORD_FRAC_BITS;
            idx  = c >>> COORD_FRAC_BITS;
            frac = c & ((longint'(1) << COORD_FRAC_BITS) - 1);
        endfunction

        // Corner order: top-left, top-right, bottom-left, bottom-right.
        function void locate(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v,
                             output logic [3:0][ADDR_W-1:0] corner,
                             output longint fu, output longint fv);
            longint st;
            longint col;
            longint row;
            longint col2;
            longint row2;
            st = eff_side();
            split(u, st, col, fu);
            split(v, st, row, fv);
            col2 = (col + 1 >= st) ? st - 1 : col + 1;
            row2 = (row + 1 >= st) ? st - 1 : row + 1;
            corner[0] = ADDR_W'((row  * st + col ) % GRID_WORDS);
            corner[1] = ADDR_W'((row  * st + col2) % GRID_WORDS);
            corner[2] = ADDR_W'((row2 * st + col ) % GRID_WORDS);
            corner[3] = ADDR_W'((row2 * st + col2) % GRID_WORDS);
        endfunction

        function void take_request(input request_t r);
            logic [3:0][ADDR_W-1:0]   corner;
            longint                   fu;
            longint                   fv;
            longint                   top;
            longint                   bot;
            logic signed [DATA_W-1:0] comp [3];
            blended_t                 want;
            if (r.op == OP_WRITE)
            begin
                store[r.addr][0] = r.wx;
                store[r.addr][1] = r.wy;
                store[r.addr][2] = r.wz;
                return;
            end
            if (r.invalid)
            begin
                want.x       = '0;
                want.y       = '0;
                want.z       = '0;
                want.skipped = 1'b1;
            end
            else
            begin
                locate(r.u, r.v, corner, fu, fv);
                for (int k = 0; k < 3; k++)
                begin
                    top     = blend(store[corner[0]][k], store[corner[1]][k], fu);
                    bot     = blend(store[corner[2]][k], store[corner[3]][k], fu);
                    comp[k] = DATA_W'(blend(top, bot, fv));
                end
                want.x       = comp[0];
                want.y       = comp[1];
                want.z       = comp[2];
                want.skipped = 1'b0;
            end
            expected_samples.push_back(want);
        endfunction

        function void match_result(input logic signed [DATA_W-1:0] x,
                                   input logic signed [DATA_W-1:0] y,
                                   input logic signed [DATA_W-1:0] z,
                                   input logic skip);
            blended_t want;
            if (expected_samples.size() == 0)
            begin
                $error("result with no sample outstanding: x %0d y %0d z %0d skipped %0b",
                       x, y, z, skip);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (x !== want.x)
            begin
                $error("sample_x: expected %0d, got %0d", want.x, x);
                errors++;
            end
            if (y !== want.y)
            begin
                $error("sample_y: expected %0d, got %0d", want.y, y);
                errors++;
            end
            if (z !== want.z)
            begin
                $error("sample_z: expected %0d, got %0d", want.z, z);
                errors++;
            end
            if (skip !== want.skipped)
            begin
                $error("skipped: expected %0b, got %0b", want.skipped, skip);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      opcode;
    logic [10:0]               entry_address;
    logic signed [DATA_W-1:0]  write_x;
    logic signed [DATA_W-1:0]  write_y;
    logic signed [DATA_W-1:0]  write_z;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;
    logic                      coord_invalid;
    logic                      cfg_we;
    logic [SIDE_W-1:0]         cfg_wdata;
    logic                      result_valid;
    logic signed [DATA_W-1:0]  sample_x;
    logic signed [DATA_W-1:0]  sample_y;
    logic signed [DATA_W-1:0]  sample_z;
    logic                      skipped;

    grid_mirror mirror;

    // Entries written since reset; a sample never touches an entry not marked here.
    bit written [GRID_WORDS];

    // Requests left in the current sender burst, and requests accepted so far.
    int burst_left = 0;
    int issued     = 0;

    grid_bilinear_sampler_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run (every request waiting out the
    // longest sender gap plus a full valid sample).
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Results last one cycle and cannot be held off: check every strobe.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            mirror.match_result(sample_x, sample_y, sample_z, skipped);
    end

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Bias coordinates toward the clamp edges and whole cell positions.
    function automatic logic signed [COORD_W-1:0] pick_coord(input longint st);
        int span;
        span = int'(st) << COORD_FRAC_BITS;
        case ($urandom_range(0, 9))
            0:       return COORD_W'($urandom);
            1:       return -COORD_W'($urandom_range(1, 3000));
            2:       return COORD_W'($urandom_range(0, int'(st) - 1) << COORD_FRAC_BITS);
            3:       return COORD_W'(span - 2 + int'($urandom_range(0, 4)));
            default: return COORD_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Drop start for a
    // random gap between bursts of requests.
    task automatic send(input request_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 50);
        end
        burst_left--;
        start         <= 1'b1;
        opcode        <= r.op;
        entry_address <= r.addr;
        write_x       <= r.wx;
        write_y       <= r.wy;
        write_z       <= r.wz;
        coord_u       <= r.u;
        coord_v       <= r.v;
        coord_invalid <= r.invalid;
        do
            @(posedge clk);
        while (busy);
        mirror.take_request(r);
        if (r.op == OP_WRITE)
            written[r.addr] = 1'b1;
        issued++;
    endtask

    // Write one grid entry; coordinate fields carry junk the block must ignore.
    task automatic write_entry(input logic [ADDR_W-1:0] addr,
                               input logic signed [DATA_W-1:0] wx,
                               input logic signed [DATA_W-1:0] wy,
                               input logic signed [DATA_W-1:0] wz);
        request_t r;
        r.op      = OP_WRITE;
        r.addr    = addr;
        r.wx      = wx;
        r.wy      = wy;
        r.wz      = wz;
        r.u       = COORD_W'($urandom);
        r.v       = COORD_W'($urandom);
        r.invalid = 1'($urandom);
        send(r);
    endtask

    // Sample the grid; fill any corner not yet written first so that the
    // request never reads an undefined entry.
    task automatic post_sample(input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v,
                               input logic bad);
        logic [3:0][ADDR_W-1:0] corner;
        longint                 fu;
        longint                 fv;
        request_t               r;
        if (!bad)
        begin
            mirror.locate(u, v, corner, fu, fv);
            for (int k = 0; k < 4; k++)
            begin
                if (!written[corner[k]])
                    write_entry(corner[k], pick_word(), pick_word(), pick_word());
            end
        end
        r.op      = OP_SAMPLE;
        r.addr    = ADDR_W'($urandom);
        r.wx      = $urandom;
        r.wy      = $urandom;
        r.wz      = $urandom;
        r.u       = u;
        r.v       = v;
        r.invalid = bad;
        send(r);
    endtask

    // Drop start, wait for every outstanding sample, then let the datapath drain.
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        while (mirror.pending() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write grid_side; call only while the block is idle.
    task automatic set_side(input logic [SIDE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        mirror.set_side(value);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                 ph;
        int                 pick;
        int                 side_val;
        int                 area;
        longint             st;
        logic [ADDR_W-1:0]  addr;

        mirror = new();

        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_WRITE;
        entry_address = '0;
        write_x       = '0;
        write_y       = '0;
        write_z       = '0;
        coord_u       = '0;
        coord_v       = '0;
        coord_invalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset side of 2: load the four cells with the
        // extremes of the data range so the blends run from min to max.
        write_entry(0, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
        write_entry(1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
        write_entry(2, -32'sd1, '0, 32'sh7FFF_FFFF);
        write_entry(3, '0, -32'sd1, 32'sh8000_0000);
        // last address of the store
        write_entry(11'h7FF, 32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_0001);

        post_sample('0, '0, 1'b0);
        // negative coordinates clamp to zero
        post_sample(-24'sd1, -24'sd1, 1'b0);
        post_sample(24'sh80_0000, 24'sh80_0000, 1'b0);
        // far beyond the grid clamps to side - 1 with no fraction
        post_sample(24'sh7F_FFFF, 24'sh7F_FFFF, 1'b0);
        // exactly at the side, and the last fraction before it
        post_sample(24'sd2048, 24'sd1324, 1'b0);
        post_sample(24'sd2047, 24'sd2047, 1'b0);
        // pure fractions inside the first cell
        post_sample(24'sd1023, 24'sd512, 1'b0);
        post_sample(24'sd1, 24'sd1023, 1'b0);
        // invalid coordinates give a skipped result whatever the coordinates
        post_sample(24'sh80_0000, 24'sh7F_FFFF, 1'b1);
        post_sample(24'sd300, 24'sd700, 1'b1);
        settle();

        // A side of zero behaves as one: every sample lands on entry 0.
        set_side(0);
        post_sample(24'sd500, 24'sd700, 1'b0);
        post_sample(24'sh7F_FFFF, -24'sd5, 1'b0);
        settle();

        // Random part: several sides, extremes included; the store persists.
        issued = 0;
        for (ph = 0; ph < SIDE_PHASES; ph++)
        begin
            case (ph)
                0:       side_val = 45;
                1:       side_val = 63;
                2:       side_val = 1;
                3:       side_val = 2;
                4:       side_val = $urandom_range(2, 45);
                5:       side_val = 0;
                6:       side_val = $urandom_range(0, 63);
                default: side_val = $urandom_range(3, 44);
            endcase
            set_side(SIDE_W'(side_val));
            st   = mirror.eff_side();
            area = int'(st * st);
            if (area > GRID_WORDS)
                area = GRID_WORDS;

            while (issued < (ph + 1) * RANDOM_ITEMS / SIDE_PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    // half the writes refill the live grid, half go anywhere
                    if ($urandom_range(0, 1) != 0)
                        addr = ADDR_W'($urandom_range(0, area - 1));
                    else
                        addr = ADDR_W'($urandom_range(0, GRID_WORDS - 1));
                    write_entry(addr, pick_word(), pick_word(), pick_word());
                end
                else if (pick < 40)
                    post_sample(COORD_W'($urandom), COORD_W'($urandom), 1'b1);
                else
                    post_sample(pick_coord(st), pick_coord(st), 1'b0);
            end
            settle();
        end

        if (mirror.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gbs_pkg.sv
src/gbs_grid_ram.sv
src/gbs_mac_unit.sv
src/grid_bilinear_sampler_unit.sv
src/gbs_checker.sv
dv/grid_bilinear_sampler_unit_tb.sv
